### design/glb_pkg.sv
// Package for the RGBA line blur: widths, register indexes, shared types
// and the constant-divide helper. No dependencies.
package glb_pkg;

  localparam int MaxRadius = 7;
  localparam int WinSlots  = 2 * MaxRadius + 1;
  localparam int NumLanes  = 4;
  localparam int AccW      = 20;   // 255*255*15 < 2^20
  localparam int TotW      = 12;   // 255 + 2*7*255 < 2^12

  localparam logic [2:0] CfgRadius = 3'd0;

  typedef logic [7:0] chan_t;
  typedef chan_t [NumLanes-1:0] pix_t;          // r,g,b,a
  typedef logic [7:0] taps_t [1:MaxRadius];

  // floor(x/255) for x <= 255*255 via reciprocal and one correction
  function automatic chan_t div255(input logic [15:0] x);
    logic [16:0] q;
    logic [16:0] t;
    begin
      t = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
      q = t >> 8;
      div255 = q[7:0];
    end
  endfunction

endpackage

### design/glb_divider.sv
// Restoring divider, one quotient bit per cycle, for the blur quotients
// and the un-premultiply step. Uses glb_pkg.
module glb_divider (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [glb_pkg::AccW-1:0]     dividend,
  input  logic [glb_pkg::AccW-1:0]     divisor,
  output logic                         done,
  output logic [glb_pkg::AccW-1:0]     quotient
);
  localparam int W = glb_pkg::AccW;
  logic [W-1:0] rem_r, rem_nxt, quo_r, quo_nxt, dvs_r;
  logic [4:0]   cnt_r, cnt_nxt;
  logic         busy_r, busy_nxt;
  logic [W:0]   trial;

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {rem_r, quo_r[W-1]} - {1'b0, dvs_r};
    if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'(W);
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (start) begin
      rem_r <= '0;
      quo_r <= dividend;
      dvs_r <= divisor;
    end else begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign done     = busy_r && (cnt_r == 5'd1);
  assign quotient = quo_nxt;
endmodule

### design/glb_lane.sv
// One channel lane: accumulates the weighted window one tap per cycle and
// divides by the kernel total. Uses glb_pkg and glb_divider.
module glb_lane (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       clr,
  input  logic                       acc_en,
  input  logic [7:0]                 weight,
  input  logic [8:0]                 pair_sum,
  input  logic                       div_start,
  input  logic [glb_pkg::AccW-1:0]   total,
  output logic                       div_done,
  output glb_pkg::chan_t             result
);
  logic [glb_pkg::AccW-1:0] acc_r, acc_nxt, quo;
  logic [16:0]              prod_r;
  logic                     prod_v_r;

  always_comb begin
    acc_nxt = acc_r;
    if (prod_v_r) acc_nxt = acc_r + glb_pkg::AccW'(prod_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= acc_en;
    end
    prod_r <= 17'(weight * pair_sum);
    if (clr) acc_r <= '0;
    else     acc_r <= acc_nxt;
  end

  // the last product is still on its way into the accumulator at start
  glb_divider u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(acc_nxt),
    .divisor(total), .done(div_done), .quotient(quo)
  );

  assign result = quo[7:0];
endmodule

### design/gaussian_line_blur_rgba.sv
// Top level of the RGBA line blur: window store, sequencer, four lanes
// and the un-premultiply merge stage. Uses glb_pkg, glb_lane, glb_divider.
//
// Each accepted pixel is premultiplied and shifted into a 15-pixel window.
// A result is accumulated one tap per cycle in each of the four channel
// lanes, then divided by the kernel total in the bit-serial lane dividers.
// When the blurred alpha is 0 or 255 the un-premultiply stage passes the
// result straight on; otherwise the three colour channels are divided in
// turn in the shared un-premultiply divider. The result is then loaded
// into the output register, waiting while that register is not yet free.
// A line end produces up to radius further results before the next pixel
// is taken. The output register lets the next pixel be taken while a
// finished result waits.
module gaussian_line_blur_rgba (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_red,
  input  logic [7:0] in_green,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_alpha,
  input  logic       in_line_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       out_line_end,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data
);
  localparam int W  = glb_pkg::AccW;
  localparam int NS = glb_pkg::WinSlots;
  localparam int NL = glb_pkg::NumLanes;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ACC   = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_UNPM  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;
  localparam logic [2:0] S_FLUSH = 3'd5;

  logic [2:0]      radius_r;
  glb_pkg::taps_t  taps_r;
  glb_pkg::pix_t   win_r [NS];
  logic [3:0]      seen_r;
  logic [2:0]      state_r;
  logic [3:0]      tap_r;        // distance being accumulated
  logic [2:0]      flush_r;      // flush shifts still to do
  logic            lend_r;       // current pixel ends the line
  logic            last_r;       // this result ends the line
  logic [glb_pkg::TotW-1:0] kern_total;
  glb_pkg::pix_t   res_r;
  logic [1:0]      uch_r;        // channel being un-premultiplied
  logic            udiv_busy_r;

  // -- configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= 3'd3;
      taps_r[1] <= 8'd137;
      taps_r[2] <= 8'd21;
      for (int i = 3; i <= glb_pkg::MaxRadius; i++) taps_r[i] <= 8'd0;
    end else if (cfg_we) begin
      if (cfg_index == glb_pkg::CfgRadius) radius_r <= cfg_data[2:0];
      else taps_r[cfg_index] <= cfg_data;
    end
  end

  // -- premultiply
  glb_pkg::pix_t in_pm;
  always_comb begin
    in_pm[0] = glb_pkg::div255(16'(in_red   * in_alpha));
    in_pm[1] = glb_pkg::div255(16'(in_green * in_alpha));
    in_pm[2] = glb_pkg::div255(16'(in_blue  * in_alpha));
    in_pm[3] = in_alpha;
  end

  logic in_fire, out_fire;
  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // -- lane feed: pair of window pixels at distance tap_r
  logic [3:0] lo_idx, hi_idx;
  logic [7:0] weight;
  logic       acc_en, lane_clr, div_start;
  logic [NL-1:0] lane_done;
  glb_pkg::pix_t lane_res;
  logic [8:0] pair [NL];

  always_comb begin
    lo_idx = 4'({1'b0, radius_r} - tap_r);
    hi_idx = 4'({1'b0, radius_r} + tap_r);
    weight = (tap_r == 4'd0) ? 8'd255 : taps_r[tap_r[2:0]];
    for (int c = 0; c < NL; c++) begin
      if (tap_r == 4'd0) pair[c] = {1'b0, win_r[lo_idx][c]};
      else pair[c] = {1'b0, win_r[lo_idx][c]} + {1'b0, win_r[hi_idx][c]};
    end
  end

  assign acc_en = (state_r == S_ACC) && (tap_r <= {1'b0, radius_r});

  for (genvar c = 0; c < NL; c++) begin : g_lane
    glb_lane u_lane (
      .clk(clk), .rst_n(rst_n), .clr(lane_clr), .acc_en(acc_en),
      .weight(weight), .pair_sum(pair[c]), .div_start(div_start),
      .total(W'(kern_total)), .div_done(lane_done[c]), .result(lane_res[c])
    );
  end

  // -- shared un-premultiply divider
  logic        udiv_start, udiv_done;
  logic [W-1:0] udiv_q;
  logic [7:0]  ucol;
  assign ucol = res_r[uch_r];
  glb_divider u_udiv (
    .clk(clk), .rst_n(rst_n), .start(udiv_start),
    .dividend(W'(ucol * 9'd255)), .divisor(W'(res_r[3])),
    .done(udiv_done), .quotient(udiv_q)
  );

  // -- sequencer
  logic [3:0] seen_inc;
  assign seen_inc = (seen_r == 4'd15) ? seen_r : seen_r + 4'd1;

  always_comb begin
    lane_clr   = 1'b0;
    div_start  = 1'b0;
    udiv_start = 1'b0;
    if (state_r == S_ACC && tap_r == {1'b0, radius_r} + 4'd1) div_start = 1'b1;
    if (state_r == S_UNPM && !udiv_busy_r && res_r[3] != 8'd0 && res_r[3] != 8'd255)
      udiv_start = 1'b1;
    if (state_r == S_IDLE || state_r == S_FLUSH) lane_clr = 1'b1;
  end

  logic out_valid_r, out_le_r, out_load;
  glb_pkg::pix_t out_r;

  assign out_load = (state_r == S_OUT) && (!out_valid_r || out_fire);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      seen_r      <= '0;
      tap_r       <= '0;
      flush_r     <= '0;
      lend_r      <= 1'b0;
      last_r      <= 1'b0;
      uch_r       <= '0;
      udiv_busy_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NS; i++) win_r[i] <= '0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_fire) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            if (seen_r == 4'd0) begin
              for (int i = 0; i < NS; i++) win_r[i] <= in_pm;
            end else begin
              for (int i = NS-1; i > 0; i--) win_r[i] <= win_r[i-1];
              win_r[0] <= in_pm;
            end
            seen_r  <= seen_inc;
            lend_r  <= in_line_end;
            flush_r <= radius_r;
            tap_r   <= '0;
            if (seen_inc > {1'b0, radius_r}) begin
              state_r <= S_ACC;
              last_r  <= in_line_end && (radius_r == 3'd0);
            end else if (in_line_end) begin
              state_r <= S_FLUSH;
            end
          end
        end
        S_ACC: begin
          if (tap_r == {1'b0, radius_r} + 4'd1) state_r <= S_DIV;
          else tap_r <= tap_r + 4'd1;
        end
        S_DIV: begin
          if (lane_done[0]) begin
            res_r   <= lane_res;
            uch_r   <= '0;
            state_r <= S_UNPM;
          end
        end
        S_UNPM: begin
          if (res_r[3] == 8'd0 || res_r[3] == 8'd255) begin
            state_r <= S_OUT;
          end else if (!udiv_busy_r) begin
            udiv_busy_r <= 1'b1;
          end else if (udiv_done) begin
            udiv_busy_r <= 1'b0;
            res_r[uch_r] <= (udiv_q > W'(255)) ? 8'd255 : udiv_q[7:0];
            if (uch_r == 2'd2) state_r <= S_OUT;
            else uch_r <= uch_r + 2'd1;
          end
        end
        S_OUT: begin
          // hold until the output register is free
          if (out_load) begin
            out_r       <= res_r;
            out_le_r    <= last_r;
            if (lend_r && flush_r != 3'd0) state_r <= S_FLUSH;
            else begin
              state_r <= S_IDLE;
              if (lend_r) seen_r <= '0;
            end
          end
        end
        S_FLUSH: begin
          if (flush_r == 3'd0) begin
            state_r <= S_IDLE;
            seen_r  <= '0;
          end else begin
            for (int i = NS-1; i > 0; i--) win_r[i] <= win_r[i-1];
            flush_r <= flush_r - 3'd1;
            tap_r   <= '0;
            // centre lands on a line pixel once seen-1+step reaches radius
            if (5'(seen_r) + 5'(radius_r - flush_r) >= 5'(radius_r)) begin
              state_r <= S_ACC;
              last_r  <= (flush_r == 3'd1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // kernel total follows the registers
  always_comb begin
    kern_total = glb_pkg::TotW'(255);
    for (int d = 1; d <= glb_pkg::MaxRadius; d++)
      if (d <= int'(radius_r)) kern_total = kern_total + {taps_r[d], 1'b0};
  end

  assign out_valid    = out_valid_r;
  assign out_red      = out_r[0];
  assign out_green    = out_r[1];
  assign out_blue     = out_r[2];
  assign out_alpha    = out_r[3];
  assign out_line_end = out_le_r;
endmodule
